// ===== design/srtu_pkg.sv =====
package srtu_pkg;

    localparam int WORD_W          = 32;
    localparam int LEN_W           = 5;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CHAR_W          = 7;
    localparam int BYTE_W          = 8;
    localparam int ALPHA_SLOTS     = 16;
    localparam int MAX_RADIX_DEF   = 16;
    localparam int MAX_DIGITS      = 32;
    localparam int CNT_W           = 6;
    localparam int ADDR_W          = 5;
    localparam int STEPS_PER_CYCLE = 8;
    localparam int ROUNDS          = WORD_W / STEPS_PER_CYCLE;
    localparam int ROUND_W         = $clog2(ROUNDS);

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HI = 2'd2;

    localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'h2B;
    localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic emit_sign;
        logic emit_digit;
    } srtu_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic div_done;
        logic neg;
        logic rd_last;
    } srtu_status_t;

endpackage

// ===== design/signed_radix_to_text_unit.sv =====
// Converts a signed 32-bit number to text in the radix of the configured digit
// alphabet, sign first, most significant digit first. Results leave on out_valid for
// one cycle each and cannot be held off. Each item yields an optional minus sign and
// D digits, D being the digit count (1 to 32); the divider resolves 8 quotient bits a
// cycle, and the digit memory is read out one digit a cycle. With an invalid
// alphabet start is ignored and nothing is emitted.
module signed_radix_to_text_unit #(
    parameter int MAX_RADIX = srtu_pkg::MAX_RADIX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [srtu_pkg::WORD_W-1:0] number,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srtu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srtu_pkg::CFG_W-1:0]         cfg_data,
    output logic                              out_valid,
    output logic [srtu_pkg::CHAR_W-1:0]        out_char,
    output logic                              last_char
);
    import srtu_pkg::*;

    srtu_cmd_t    cmd;
    srtu_status_t status;

    assign cfg_ready = 1'b1;

    srtu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    srtu_datapath #(
        .MAX_RADIX (MAX_RADIX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (number),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last_char (last_char)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.emit_sign, cmd.emit_digit}))
        else $error("controller issued conflicting commands");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy)
        else $error("conversion started without busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char |=> !out_valid)
        else $error("character transaction right after the final one");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == MINUS_CHAR |-> !last_char)
        else $error("sign marked as final character");

endmodule

// ===== design/srtu_ctrl.sv =====
module srtu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  srtu_pkg::srtu_status_t status,
    output srtu_pkg::srtu_cmd_t    cmd,
    output logic                  busy
);
    import srtu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && status.alpha_ok)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (round_reg == ROUND_W'(ROUNDS - 1));
                round_next   = round_reg + 1'b1;
                if (cmd.div_last && status.div_done)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== design/srtu_datapath.sv =====
module srtu_datapath #(
    parameter int MAX_RADIX = srtu_pkg::MAX_RADIX_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [srtu_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srtu_pkg::CFG_W-1:0]              cfg_data,
    input  logic signed [srtu_pkg::WORD_W-1:0]      number,
    input  srtu_pkg::srtu_cmd_t                     cmd,
    output srtu_pkg::srtu_status_t                  status,
    output logic                                   out_valid,
    output logic [srtu_pkg::CHAR_W-1:0]             out_char,
    output logic                                   last_char
);
    import srtu_pkg::*;

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int PART_W  = DIGIT_W + 1;

    logic [LEN_W-1:0]   alen_reg;
    logic [CFG_W-1:0]   digits_lo_reg;
    logic [CFG_W-1:0]   digits_hi_reg;

    logic [WORD_W-1:0]  work_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;

    logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic               p1_valid_reg;
    logic               p1_sign_reg;
    logic               p1_last_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic [BYTE_W-1:0]  glyph_byte [ALPHA_SLOTS];
    logic               alpha_ok;
    logic [WORD_W-1:0]  magnitude;
    logic [WORD_W-1:0]  work_next;
    logic [DIGIT_W-1:0] rem_next;
    logic [BYTE_W-1:0]  sel_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alen_reg      <= '0;
            digits_lo_reg <= '0;
            digits_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA_LEN: alen_reg      <= cfg_data[LEN_W-1:0];
                CFG_DIGITS_LO: digits_lo_reg <= cfg_data;
                CFG_DIGITS_HI: digits_hi_reg <= cfg_data;
                default:       alen_reg      <= alen_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < ALPHA_SLOTS / 2; k++)
        begin
            glyph_byte[k]                   = digits_lo_reg[k*BYTE_W +: BYTE_W];
            glyph_byte[k + ALPHA_SLOTS / 2] = digits_hi_reg[k*BYTE_W +: BYTE_W];
        end
    end

    // alphabet check
    always_comb
    begin
        alpha_ok = (alen_reg >= LEN_W'(2)) && (alen_reg <= LEN_W'(MAX_RADIX));
        for (int a = 0; a < ALPHA_SLOTS; a++)
        begin
            if (LEN_W'(a) < alen_reg)
            begin
                if (glyph_byte[a] == PLUS_BYTE || glyph_byte[a] == MINUS_BYTE ||
                    glyph_byte[a] < PRINT_LO || glyph_byte[a] > PRINT_HI)
                begin
                    alpha_ok = 1'b0;
                end
                for (int b = a + 1; b < ALPHA_SLOTS; b++)
                begin
                    if (LEN_W'(b) < alen_reg && glyph_byte[b] == glyph_byte[a])
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign magnitude = number[WORD_W-1] ? (WORD_W'(0) - $unsigned(number)) : $unsigned(number);

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        logic [PART_W-1:0] part;
        logic              qbit;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int s = 0; s < STEPS_PER_CYCLE; s++)
        begin
            part = {rem_next, work_next[WORD_W-1]};
            qbit = (LEN_W'(part) >= alen_reg);
            if (qbit)
            begin
                rem_next = DIGIT_W'(LEN_W'(part) - alen_reg);
            end
            else
            begin
                rem_next = part[DIGIT_W-1:0];
            end
            work_next = {work_next[WORD_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg   <= '0;
            rem_reg    <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            work_reg <= magnitude;
            rem_reg  <= '0;
            neg_reg  <= number[WORD_W-1];
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            if (cmd.div_last)
            begin
                rem_reg    <= '0;
                cnt_reg    <= cnt_reg + 1'b1;
                rd_idx_reg <= cnt_reg[ADDR_W-1:0];
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
        else if (cmd.emit_digit)
        begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
    end

    // digit memory
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && cmd.div_last)
        begin
            digit_store[cnt_reg[ADDR_W-1:0]] <= rem_next;
        end
        if (cmd.emit_digit)
        begin
            rd_data_reg <= digit_store[rd_idx_reg];
        end
    end

    // emit pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p1_sign_reg   <= 1'b0;
            p1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= cmd.emit_sign || cmd.emit_digit;
            p1_sign_reg   <= cmd.emit_sign;
            p1_last_reg   <= cmd.emit_digit && (rd_idx_reg == '0);
            out_valid_reg <= p1_valid_reg;
            out_last_reg  <= p1_valid_reg && p1_last_reg;
        end
    end

    assign sel_byte = glyph_byte[4'(rd_data_reg)];

    always_ff @(posedge clk)
    begin
        out_char_reg <= p1_sign_reg ? MINUS_CHAR : sel_byte[CHAR_W-1:0];
    end

    assign status.alpha_ok = alpha_ok;
    assign status.div_done = (work_next == '0) || (cnt_reg == CNT_W'(MAX_DIGITS - 1));
    assign status.neg      = neg_reg;
    assign status.rd_last  = (rd_idx_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = out_last_reg;

endmodule
